[hdl/dq_pkg.sv]
`timescale 1ns / 1ps

package dq_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Port field widths
  localparam int CMD_W  = 3;
  localparam int ELEM_W = 32;
  localparam int STAT_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic              wr_front;     // push at front
    logic              wr_back;      // push at back
    logic              pop_front;
    logic              pop_back;
    logic              dump_start;   // load dump pointer and remaining count
    logic              rd_en;        // read one ring entry for the dump
    logic              out_load;     // load the output register
    logic              out_from_mem; // output word carries the read element
    logic [STAT_W-1:0] out_status;
  } dq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic rd_last;   // entry just read is the back of the queue
    logic out_free;  // output register can take a word this cycle
  } dq_stat_t;

endpackage

[hdl/dq_ctrl.sv]
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [dq_pkg::CMD_W-1:0] in_cmd,
  input  dq_pkg::dq_stat_t         stat,
  output dq_pkg::dq_cmd_t          cmd
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DUMP_RD  = 2'd1;
  localparam logic [1:0] S_DUMP_OUT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  // Take a new word only when idle and the output register can hold its result
  assign in_ready = (state_r == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  // Decode commands and sequence the dump
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd) inside
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
              cmd.out_load = 1'b1;
              if (stat.full) begin
                cmd.out_status = dq_pkg::STAT_FULL;
              end else begin
                cmd.out_status = dq_pkg::STAT_OK;
                cmd.wr_front   = (in_cmd == dq_pkg::CMD_PUSH_FRONT);
                cmd.wr_back    = (in_cmd == dq_pkg::CMD_PUSH_BACK);
              end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
              cmd.out_load = 1'b1;
              if (stat.empty) begin
                cmd.out_status = dq_pkg::STAT_EMPTY;
              end else begin
                cmd.out_status = dq_pkg::STAT_OK;
                cmd.pop_front  = (in_cmd == dq_pkg::CMD_POP_FRONT);
                cmd.pop_back   = (in_cmd == dq_pkg::CMD_POP_BACK);
              end
            end
            dq_pkg::CMD_DUMP: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = dq_pkg::STAT_EMPTY;
              end else begin
                cmd.dump_start = 1'b1;
                state_nxt      = S_DUMP_RD;
              end
            end
            default: begin
              // drop undefined commands without a result
            end
          endcase
        end
      end
      S_DUMP_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_status   = dq_pkg::STAT_OK;
          state_nxt        = stat.rd_last ? S_IDLE : S_DUMP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/dq_dpath.sv]
`timescale 1ns / 1ps

module dq_dpath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [dq_pkg::ELEM_W-1:0] in_value,
  input  dq_pkg::dq_cmd_t                  cmd,
  output dq_pkg::dq_stat_t                 stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dq_pkg::ELEM_W-1:0] out_element,
  output logic [dq_pkg::STAT_W-1:0]        out_status,
  output logic                             out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  // Ring storage
  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         rd_ptr_r;
  logic [CW-1:0]         rd_left_r;
  logic                  rd_last_r;
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic                           out_valid_r;
  logic signed [dq_pkg::ELEM_W-1:0] out_element_r;
  logic [dq_pkg::STAT_W-1:0]      out_status_r;
  logic                           out_last_r;

  logic [AW-1:0]         front_dec;
  logic [AW-1:0]         front_inc;
  logic [AW-1:0]         rd_ptr_inc;
  logic [SW-1:0]         back_sum;
  logic [AW-1:0]         back_slot;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic signed [DATA_WIDTH-1:0] rd_data_s;

  // Ring pointer arithmetic with wrap at DEPTH
  assign front_dec  = (front_r == '0) ? LAST_SLOT : front_r - AW'(1);
  assign front_inc  = (front_r == LAST_SLOT) ? '0 : front_r + AW'(1);
  assign rd_ptr_inc = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
  assign back_sum   = SW'(front_r) + SW'(count_r);
  assign back_slot  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

  // Status toward the controller
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CW'(DEPTH));
  assign stat.rd_last  = rd_last_r;
  assign stat.out_free = !out_valid_r || out_ready;

  // Update front index and fill count
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    if (cmd.wr_front) begin
      front_nxt = front_dec;
      count_nxt = count_r + CW'(1);
    end else if (cmd.wr_back) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_front) begin
      front_nxt = front_inc;
      count_nxt = count_r - CW'(1);
    end else if (cmd.pop_back) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Write port: keep the low DATA_WIDTH bits of the pushed word
  assign mem_we   = cmd.wr_front || cmd.wr_back;
  assign mem_addr = cmd.wr_front ? front_dec : back_slot;
  assign wr_data  = DATA_WIDTH'($unsigned(in_value));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_data;
    end
  end

  // Registered read port for the dump
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // Walk the ring from front to back during a dump
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      rd_left_r <= '0;
      rd_last_r <= 1'b0;
    end else if (cmd.dump_start) begin
      rd_ptr_r  <= front_r;
      rd_left_r <= count_r;
      rd_last_r <= 1'b0;
    end else if (cmd.rd_en) begin
      rd_ptr_r  <= rd_ptr_inc;
      rd_left_r <= rd_left_r - CW'(1);
      rd_last_r <= (rd_left_r == CW'(1));
    end
  end

  // Sign-extend the stored element to the port width
  assign rd_data_s = $signed(rd_data_r);

  // Output register: load a result word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      if (cmd.out_from_mem) begin
        out_element_r <= dq_pkg::ELEM_W'(rd_data_s);
        out_last_r    <= rd_last_r;
      end else begin
        out_element_r <= '0;
        out_last_r    <= 1'b1;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_element = out_element_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count exceeds ring depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_front || cmd.wr_back) |-> !stat.full)
    else $error("write into a full ring");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_front || cmd.pop_back) |-> !stat.empty)
    else $error("pop from an empty ring");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (rd_left_r != '0))
    else $error("dump reads past the back of the queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("output word overwritten before it was taken");
`endif

endmodule

[hdl/double_ended_queue.sv]
`timescale 1ns / 1ps

// Double-ended queue of signed words held in a ring of DEPTH entries. Each input
// word carries a command: push front, push back, pop front, pop back or dump.
// A push or pop returns one word with status ok, empty (pop of an empty queue)
// or full (push onto a full queue, contents unchanged), element zero and last
// set. A dump returns the stored elements front to back with last on the back
// element, or a single empty word when nothing is stored. Undefined command
// codes are taken and give no result. Push, pop and undefined commands stream
// at one word per cycle while out_ready is high. A dump loads the read pointer,
// then reads each stored element through the single registered read port of
// the ring storage and moves it to the output register once that is free;
// no new input word is taken until the dump has delivered its last element.
// Stored elements keep their low DATA_WIDTH bits and are sign-extended on dump.
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dq_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [dq_pkg::ELEM_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dq_pkg::ELEM_W-1:0] out_element,
  output logic [dq_pkg::STAT_W-1:0]        out_status,
  output logic                             out_last
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd)
  );

  dq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_value    (in_value),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_element (out_element),
    .out_status  (out_status),
    .out_last    (out_last)
  );

endmodule
